>>> rtl/core/stereo_sine_tremolo_core_macros.svh
// Assertion macros for the stereo sine tremolo core.
// Included by the top level; relies on clk and arst_n being in scope.
`ifndef STEREO_SINE_TREMOLO_CORE_MACROS_SVH
`define STEREO_SINE_TREMOLO_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/stt_pkg.sv
// Shared constants, types and the sine table builder of the stereo sine tremolo.
// No dependencies; the core files other than the macros header refer to it by scoped names.
package stt_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int SAMPLE_BITS     = 24;
	localparam int QUARTER_SIZE    = 1 << SINE_TABLE_BITS;
	localparam int ROM_DATA_BITS   = 15;
	localparam int ENV_BITS        = 16;
	localparam int GAIN_BITS       = ENV_BITS + 1;
	localparam int PHASE_BITS      = 32;
	localparam int SNAP_BITS       = 16;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int CFG_DATA_BITS   = 32;

	// Digit-serial multiplier: four digits of four bits cover a 16-bit multiplier.
	localparam int DIGIT_BITS      = 4;
	localparam int MUL_DIGITS      = 4;
	localparam int MPLIER_BITS     = DIGIT_BITS * MUL_DIGITS;
	localparam int DIGIT_CNT_BITS  = $clog2(MUL_DIGITS);
	localparam int MUL_W           = SAMPLE_BITS + 1;
	localparam int MAC_W           = MUL_W + DIGIT_BITS + 1;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef logic signed [SAMPLE_BITS-1:0]     sample_t;
	typedef logic signed [MUL_W-1:0]           mul_t;
	typedef logic signed [MUL_W:0]             fin_t;
	typedef logic signed [MAC_W-1:0]           mac_t;
	typedef logic [MPLIER_BITS-1:0]            mplier_t;
	typedef logic [DIGIT_CNT_BITS-1:0]         digit_cnt_t;
	typedef logic [ENV_BITS-1:0]               env_t;
	typedef logic [GAIN_BITS-1:0]              gain_t;
	typedef logic [PHASE_BITS-1:0]             phase_t;
	typedef logic [SNAP_BITS-1:0]              snap_t;
	typedef logic [SINE_TABLE_BITS:0]          rom_addr_t;
	typedef logic [SINE_TABLE_BITS-1:0]        rom_idx_t;
	typedef logic [ROM_DATA_BITS-1:0]          rom_data_t;
	typedef logic [CFG_INDEX_BITS-1:0]         cfg_index_t;
	typedef logic [CFG_DATA_BITS-1:0]          cfg_data_t;
	typedef rom_data_t                         sine_rom_t [0:QUARTER_SIZE];

	localparam cfg_index_t REG_PHASE_INC = 2'd0;
	localparam cfg_index_t REG_DEPTH     = 2'd1;

	localparam digit_cnt_t LAST_DIGIT     = digit_cnt_t'(MUL_DIGITS - 1);
	localparam rom_addr_t  QUARTER_ADDR   = rom_addr_t'(QUARTER_SIZE);
	localparam env_t       ENV_MID        = env_t'(32768);
	localparam gain_t      GAIN_ONE       = gain_t'(65536);
	localparam phase_t     PHASE_INC_INIT = phase_t'(26844);

	// Control of one serial multiplier: load operands, or retire one digit.
	typedef struct packed {
		logic load;
		logic step;
	} mul_ctl_t;

	// Quarter-wave sine in Q0.15, from a Q2.30 Taylor series through x^15/15!.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t       t;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned pos;
		longint unsigned neg;
		longint unsigned r;
		for (int k = 0; k <= QUARTER_SIZE; k++) begin
			x    = (longint'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
			x2   = (x * x) >> 30;
			term = x;
			pos  = x;
			neg  = 0;
			term = ((term * x2) >> 30) / 64'd6;   neg = neg + term;
			term = ((term * x2) >> 30) / 64'd20;  pos = pos + term;
			term = ((term * x2) >> 30) / 64'd42;  neg = neg + term;
			term = ((term * x2) >> 30) / 64'd72;  pos = pos + term;
			term = ((term * x2) >> 30) / 64'd110; neg = neg + term;
			term = ((term * x2) >> 30) / 64'd156; pos = pos + term;
			term = ((term * x2) >> 30) / 64'd210; neg = neg + term;
			r    = (pos > neg) ? pos - neg : 64'd0;
			r    = (r + 64'd16384) >> 15;
			t[k] = (r > 64'd32767) ? rom_data_t'(32767) : r[ROM_DATA_BITS-1:0];
		end
		return t;
	endfunction

endpackage

>>> rtl/core/stt_if.sv
// Handshake channel interfaces of the stereo sine tremolo: frames in, results out,
// configuration writes. Depends on stt_pkg for payload types.
interface stt_sample_if;
	logic             valid;
	logic             ready;
	stt_pkg::sample_t left_in;
	stt_pkg::sample_t right_in;
	logic             block_end;

	modport source (output valid, output left_in, output right_in, output block_end,
		input ready);
	modport sink (input valid, input left_in, input right_in, input block_end,
		output ready);
endinterface

interface stt_result_if;
	logic             valid;
	logic             ready;
	stt_pkg::sample_t left_out;
	stt_pkg::sample_t right_out;
	stt_pkg::snap_t   published_phase;

	modport source (output valid, output left_out, output right_out,
		output published_phase, input ready);
	modport sink (input valid, input left_out, input right_out,
		input published_phase, output ready);
endinterface

interface stt_cfg_if;
	logic                valid;
	logic                ready;
	stt_pkg::cfg_index_t reg_index;
	stt_pkg::cfg_data_t  write_data;

	modport source (output valid, output reg_index, output write_data, input ready);
	modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

>>> rtl/core/stt_sine_rom.sv
// Quarter-wave sine ROM with a registered read port.
// Contents come from stt_pkg::build_sine_rom at elaboration.
module stt_sine_rom (
	input  logic               clk,
	input  logic               rd_en,
	input  stt_pkg::rom_addr_t addr,
	output stt_pkg::rom_data_t rd_data
);

	localparam stt_pkg::sine_rom_t ROM = stt_pkg::build_sine_rom();

	stt_pkg::rom_data_t rd_data_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= ROM[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/core/stt_serial_mul.sv
// Digit-serial signed multiplier, least significant multiplier digit first.
// Keeps floor(product / 16^k) after k digits. Depends on stt_pkg.
module stt_serial_mul (
	input  logic              clk,
	input  stt_pkg::mul_ctl_t ctl,
	input  stt_pkg::mul_t     mcand,
	input  stt_pkg::mplier_t  mplier,
	output stt_pkg::mul_t     acc
);

	stt_pkg::mul_t    mcand_q;
	stt_pkg::mplier_t digits_q;
	stt_pkg::mul_t    acc_q;
	stt_pkg::mac_t    sum_w;

	// Dropping the low digit each step is exact flooring, as later digits only
	// add multiples of the dropped weight.
	assign sum_w = stt_pkg::mac_t'(acc_q)
		+ mcand_q * $signed({1'b0, digits_q[stt_pkg::DIGIT_BITS-1:0]});

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mcand_q  <= mcand;
			digits_q <= mplier;
			acc_q    <= '0;
		end else if (ctl.step) begin
			digits_q <= digits_q >> stt_pkg::DIGIT_BITS;
			acc_q    <= stt_pkg::mul_t'(sum_w >>> stt_pkg::DIGIT_BITS);
		end
	end

	assign acc = acc_q;

endmodule

>>> rtl/core/stereo_sine_tremolo_core.sv
// Top level of the stereo sine tremolo: LFO phase, envelope and gain, output register.
// Depends on stt_pkg, stt_if, stt_sine_rom, stt_serial_mul and the macros header.
//
// Usage. Stereo frames arrive on the samples channel, one beat per frame carrying
// left_in, right_in and block_end. Each frame yields exactly one beat on the results
// channel: both samples scaled by the current tremolo gain, plus the LFO phase
// published at the most recent block end. The cfg channel writes phase_increment
// (index 0) and depth_amount (index 1); it is always ready and other indexes are
// dropped. Write it only while no frame is in flight.
// Sequence. The ROM is read on the edge that takes a frame; then depth times
// envelope and sample times gain are worked out one after another, a digit at a
// time, in the digit-serial multipliers; the result register loads from the final
// state, and the next frame can be taken in the cycle after that. One frame is
// worked on at a time, and samples.ready is high only while waiting for a frame.
// Stalls. If the result register is full and the receiver holds results.ready low,
// the finished frame waits in the final state; no new frame is taken until it frees.
// Reset. arst_n clears the phase and the block-end snapshot to zero, sets the
// increment to 26844 and the depth to zero (bypass), and empties the output.
`include "stereo_sine_tremolo_core_macros.svh"

module stereo_sine_tremolo_core (
	input  logic       clk,
	input  logic       arst_n,
	stt_sample_if.sink samples,
	stt_result_if.source results,
	stt_cfg_if.sink    cfg
);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_ENV  = 3'd2;
	localparam logic [2:0] ST_GAIN = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]          state_q;
	stt_pkg::digit_cnt_t cnt_q;

	// Configuration and LFO state.
	stt_pkg::phase_t phase_inc_q;
	stt_pkg::env_t   depth_q;
	stt_pkg::phase_t phase_q;
	stt_pkg::snap_t  snap_q;
	stt_pkg::phase_t phase_next;

	// Frame being worked on.
	stt_pkg::sample_t left_q;
	stt_pkg::sample_t right_q;
	logic             negative_q;
	logic             gain_top_q;

	// Output register.
	logic             out_valid_q;
	stt_pkg::sample_t left_out_q;
	stt_pkg::sample_t right_out_q;
	stt_pkg::snap_t   pub_phase_q;

	logic               in_acc;
	logic               out_free;
	stt_pkg::rom_idx_t  rom_idx;
	stt_pkg::rom_addr_t rom_addr;
	stt_pkg::rom_data_t rom_data;
	stt_pkg::env_t      env_w;
	stt_pkg::gain_t     gain_w;
	stt_pkg::mul_ctl_t  depth_ctl;
	stt_pkg::mul_ctl_t  sample_ctl;
	stt_pkg::mul_t      depth_acc;
	stt_pkg::mul_t      left_acc;
	stt_pkg::mul_t      right_acc;
	stt_pkg::mul_t      left_mc;
	stt_pkg::mul_t      right_mc;
	stt_pkg::fin_t      left_fin;
	stt_pkg::fin_t      right_fin;

	assign in_acc        = samples.valid && samples.ready;
	assign samples.ready = (state_q == ST_IDLE);
	assign cfg.ready     = 1'b1;
	assign out_free      = !out_valid_q || results.ready;
	assign phase_next    = phase_q + phase_inc_q;

	// Top two phase bits give the quadrant; odd quadrants read the table mirrored.
	assign rom_idx  = phase_q[stt_pkg::PHASE_BITS-3 -: stt_pkg::SINE_TABLE_BITS];
	assign rom_addr = phase_q[stt_pkg::PHASE_BITS-2]
		? stt_pkg::QUARTER_ADDR - {1'b0, rom_idx}
		: {1'b0, rom_idx};

	stt_sine_rom u_sine_rom (
		.clk     (clk),
		.rd_en   (in_acc),
		.addr    (rom_addr),
		.rd_data (rom_data)
	);

	// Envelope is half scale plus the signed sine, so it stays within 1 .. 65535.
	assign env_w = negative_q
		? stt_pkg::ENV_MID - {1'b0, rom_data}
		: stt_pkg::ENV_MID + {1'b0, rom_data};

	// After four digits depth_acc holds floor(depth * env / 2^16), at most 65534,
	// so the gain never drops below two.
	assign gain_w = stt_pkg::GAIN_ONE - {1'b0, depth_acc[stt_pkg::ENV_BITS-1:0]};

	assign depth_ctl.load  = (state_q == ST_LOAD);
	assign depth_ctl.step  = (state_q == ST_ENV);
	assign sample_ctl.load = (state_q == ST_GAIN);
	assign sample_ctl.step = (state_q == ST_MUL);

	assign left_mc  = stt_pkg::mul_t'(left_q);
	assign right_mc = stt_pkg::mul_t'(right_q);

	stt_serial_mul u_depth_mul (
		.clk    (clk),
		.ctl    (depth_ctl),
		.mcand  (stt_pkg::mul_t'({1'b0, depth_q})),
		.mplier (env_w),
		.acc    (depth_acc)
	);

	// The sample multipliers see the low sixteen gain bits; the top bit, set only
	// for unity gain, adds the whole sample once the digits are done.
	stt_serial_mul u_left_mul (
		.clk    (clk),
		.ctl    (sample_ctl),
		.mcand  (left_mc),
		.mplier (gain_w[stt_pkg::MPLIER_BITS-1:0]),
		.acc    (left_acc)
	);

	stt_serial_mul u_right_mul (
		.clk    (clk),
		.ctl    (sample_ctl),
		.mcand  (right_mc),
		.mplier (gain_w[stt_pkg::MPLIER_BITS-1:0]),
		.acc    (right_acc)
	);

	assign left_fin  = stt_pkg::fin_t'(left_acc)
		+ stt_pkg::fin_t'(gain_top_q ? left_mc : stt_pkg::mul_t'(0));
	assign right_fin = stt_pkg::fin_t'(right_acc)
		+ stt_pkg::fin_t'(gain_top_q ? right_mc : stt_pkg::mul_t'(0));

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_inc_q <= stt_pkg::PHASE_INC_INIT;
			depth_q     <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.reg_index)
				stt_pkg::REG_PHASE_INC: phase_inc_q <= cfg.write_data;
				stt_pkg::REG_DEPTH:     depth_q <= cfg.write_data[stt_pkg::ENV_BITS-1:0];
				default: ;
			endcase
		end
	end

	// The phase advances as the frame is taken; its old value has already
	// addressed the ROM on that edge. A block end captures the advanced phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			snap_q  <= '0;
		end else if (in_acc) begin
			phase_q <= phase_next;
			if (samples.block_end) begin
				snap_q <= phase_next[stt_pkg::PHASE_BITS-1 -: stt_pkg::SNAP_BITS];
			end
		end
	end

	// Frame payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			left_q     <= samples.left_in;
			right_q    <= samples.right_in;
			negative_q <= phase_q[stt_pkg::PHASE_BITS-1];
		end
		if (state_q == ST_GAIN) begin
			gain_top_q <= gain_w[stt_pkg::GAIN_BITS-1];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_ENV;
					cnt_q   <= '0;
				end
				ST_ENV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == stt_pkg::LAST_DIGIT) begin
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: begin
					state_q <= ST_MUL;
					cnt_q   <= '0;
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == stt_pkg::LAST_DIGIT) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: it fills from the final state and empties on a beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			left_out_q  <= stt_pkg::sample_t'(left_fin);
			right_out_q <= stt_pkg::sample_t'(right_fin);
			pub_phase_q <= snap_q;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.left_out        = left_out_q;
	assign results.right_out       = right_out_q;
	assign results.published_phase = pub_phase_q;

	// Checks.
	`STT_ASSERT_NEXT(a_phase_advance, in_acc, phase_q == $past(phase_q) + $past(phase_inc_q), "phase did not advance by the increment")
	`STT_ASSERT_NEXT(a_phase_hold, !in_acc, $stable(phase_q), "phase moved without a frame")
	`STT_ASSERT_SAME(a_gain_floor, state_q == ST_GAIN, gain_w >= stt_pkg::gain_t'(2), "tremolo gain fell below two")
	`STT_ASSERT_NEXT(a_bypass, state_q == ST_DONE && out_free && depth_q == '0, results.left_out == $past(left_q) && results.right_out == $past(right_q), "zero depth did not pass samples unchanged")

endmodule

>>> verif/tb_stereo_sine_tremolo_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for stereo_sine_tremolo_core: drives stereo frames and register
// writes, predicts every result beat and compares it. Depends on stt_pkg and stt_if.
module tb_stereo_sine_tremolo_core;
	import stt_pkg::*;

	// Register indexes that the block does not decode; writes to them must be dropped.
	localparam cfg_index_t REG_UNMAPPED_A = 2'd2;
	localparam cfg_index_t REG_UNMAPPED_B = 2'd3;

	localparam sample_t     SAMPLE_MAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t     SAMPLE_MIN   = ~SAMPLE_MAX;
	localparam int unsigned CYCLE_LIMIT  = 300000;
	localparam int          SETTLE_TICKS = 24;
	localparam int          LONG_HOLD    = 300;

	// One result beat as the block should produce it.
	typedef struct packed {
		sample_t left;
		sample_t right;
		snap_t   phase;
	} tremolo_frame_t;

	logic clk = 1'b0;
	logic arst_n;

	stt_sample_if samples_ch ();
	stt_result_if results_ch ();
	stt_cfg_if    cfg_ch ();

	stereo_sine_tremolo_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch),
		.cfg     (cfg_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state: the LFO, the published snapshot and our copy of the registers.
	rom_data_t sine_quarter_ref [0:QUARTER_SIZE];
	phase_t    lfo_phase_now;
	snap_t     published_now;
	phase_t    phase_step;
	env_t      depth_setting;

	tremolo_frame_t expected_frames [$];
	tremolo_frame_t oldest_frame;
	int             mismatches;

	// Idling controls. The sender and the receiver each insert random idle bursts
	// while their flag is set; a non-zero long_hold_cycles makes the receiver refuse
	// results for that many cycles, once.
	bit src_gaps;
	bit sink_stalls;
	int long_hold_cycles;

	// Quarter-wave sine entry in Q0.15. The argument is taken in Q2.30, then the odd
	// Taylor terms up to x^15/15! are summed with every product and division truncated,
	// and the sum is rounded half up to fifteen fraction bits and capped.
	function automatic rom_data_t taylor_sine(input int unsigned k);
		longint unsigned x;
		longint unsigned x_sq;
		longint unsigned term;
		longint unsigned pos;
		longint unsigned neg;
		longint unsigned r;
		x    = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
		x_sq = (x * x) >> 30;
		term = x;
		pos  = x;
		neg  = 0;
		for (int n = 1; n <= 7; n++) begin
			term = (term * x_sq) >> 30;
			term = term / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		r = (pos > neg) ? pos - neg : 64'd0;
		r = (r + 64'd16384) >> 15;
		return (r > 64'd32767) ? rom_data_t'(32767) : r[ROM_DATA_BITS-1:0];
	endfunction

	// Sample times a Q1.16 gain, floored by an arithmetic shift.
	function automatic sample_t scale_sample(input sample_t value, input longint gain);
		longint product;
		longint floored;
		product = longint'(value) * gain;
		floored = product >>> 16;
		return sample_t'(floored);
	endfunction

	// Works out the result of one accepted frame and moves the LFO on by one sample.
	// The gain uses the phase before the step; the snapshot, on a block end, the phase
	// after it, and the same beat already carries the new snapshot.
	function automatic tremolo_frame_t tremolo_predict(input sample_t left, input sample_t right,
			input logic last_of_block);
		logic [SINE_TABLE_BITS+1:0] top;
		logic [1:0]                 quadrant;
		rom_idx_t                   idx;
		rom_addr_t                  tbl_addr;
		rom_data_t                  magnitude;
		longint                     sine;
		longint                     env;
		longint                     gain;
		tremolo_frame_t             res;
		top       = lfo_phase_now[PHASE_BITS-1 -: SINE_TABLE_BITS+2];
		quadrant  = top[SINE_TABLE_BITS+1 -: 2];
		idx       = top[SINE_TABLE_BITS-1:0];
		// Odd quadrants run the table backwards; the second half cycle is negative.
		tbl_addr  = quadrant[0] ? QUARTER_ADDR - {1'b0, idx} : {1'b0, idx};
		magnitude = sine_quarter_ref[tbl_addr];
		sine      = quadrant[1] ? -longint'(magnitude) : longint'(magnitude);
		env       = 32768 + sine;
		gain      = 65536 - ((longint'(depth_setting) * env) >>> 16);
		res.left  = scale_sample(left, gain);
		res.right = scale_sample(right, gain);
		lfo_phase_now = lfo_phase_now + phase_step;
		if (last_of_block) begin
			published_now = lfo_phase_now[PHASE_BITS-1 -: SNAP_BITS];
		end
		res.phase = published_now;
		return res;
	endfunction

	// Mostly full-scale random audio, with the two extremes and values around zero
	// mixed in so that the floor on negative products is exercised often.
	function automatic sample_t rand_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MIN;
			1: return SAMPLE_MAX;
			2: return sample_t'(int'($urandom_range(0, 16)) - 8);
			default: return sample_t'($urandom());
		endcase
	endfunction

	function automatic logic rand_block_end(input int unsigned one_in);
		return ($urandom_range(1, one_in) == 1);
	endfunction

	// Offers one frame and waits for the beat. valid is left high on return so that a
	// following frame can go out back to back; await_results lowers it.
	task automatic send_frame(input sample_t left, input sample_t right, input logic blk);
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			samples_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		samples_ch.valid     <= 1'b1;
		samples_ch.left_in   <= left;
		samples_ch.right_in  <= right;
		samples_ch.block_end <= blk;
		@(posedge clk);
		while (!samples_ch.ready) @(posedge clk);
		expected_frames.push_back(tremolo_predict(left, right, blk));
	endtask

	// Stops offering frames and waits until every predicted beat has been checked.
	task automatic await_results();
		samples_ch.valid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
	endtask

	// One register write beat; valid stays high for a following write.
	task automatic write_reg(input cfg_index_t idx, input cfg_data_t data);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.reg_index  <= idx;
		cfg_ch.write_data <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_PHASE_INC: phase_step    = data;
			REG_DEPTH:     depth_setting = data[ENV_BITS-1:0];
			default: ;
		endcase
	endtask

	// Both registers, written only once the block has gone idle.
	task automatic set_lfo(input cfg_data_t step, input cfg_data_t depth);
		write_reg(REG_PHASE_INC, step);
		write_reg(REG_DEPTH, depth);
		cfg_ch.valid <= 1'b0;
	endtask

	// Reset settings: depth zero, so every sample must come back untouched, and the
	// snapshot must follow the phase on block ends only.
	task automatic test_bypass_extremes();
		send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
		send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
		send_frame(sample_t'(0), sample_t'(-1), 1'b0);
		send_frame(sample_t'(-1), sample_t'(1), 1'b1);
		send_frame(sample_t'(24'h555555), sample_t'(24'hAAAAAA), 1'b0);
		send_frame(sample_t'(24'hAAAAAA), sample_t'(24'h555555), 1'b1);
		await_results();
	endtask

	// A quarter cycle per sample with full depth lands on the start of every quadrant,
	// which gives the largest and the smallest envelope and the mirrored table end.
	task automatic test_quadrant_edges();
		set_lfo(32'h4000_0000, 32'h0000_FFFF);
		for (int i = 0; i < 8; i++) begin
			send_frame(i[0] ? SAMPLE_MIN : SAMPLE_MAX, i[0] ? SAMPLE_MAX : SAMPLE_MIN,
				logic'(i % 3 == 2));
		end
		await_results();
	endtask

	// Undecoded indexes must leave the registers alone, and bits above a register's
	// width are dropped. Also covers the largest and the zero phase increment.
	task automatic test_register_map();
		write_reg(REG_UNMAPPED_A, 32'hFFFF_FFFF);
		write_reg(REG_UNMAPPED_B, 32'h1234_5678);
		write_reg(REG_DEPTH, 32'hFFFF_8000);
		cfg_ch.valid <= 1'b0;
		for (int i = 0; i < 4; i++) send_frame(rand_sample(), rand_sample(), logic'(i == 3));
		await_results();
		set_lfo(32'hFFFF_FFFF, 32'h0001_FFFF);
		for (int i = 0; i < 4; i++) send_frame(rand_sample(), rand_sample(), logic'(i[0]));
		await_results();
		set_lfo(32'h0000_0000, 32'hFFFF_0001);
		for (int i = 0; i < 3; i++) send_frame(rand_sample(), rand_sample(), 1'b1);
		await_results();
	endtask

	// Several register settings in turn, each followed by random frames with idling
	// on both sides. Large increments sweep the whole table within one setting.
	task automatic test_random_settings();
		cfg_data_t step;
		cfg_data_t depth;
		for (int setting = 0; setting < 6; setting++) begin
			case (setting)
				0: begin step = $urandom();                  depth = 32'h0000_FFFF; end
				1: begin step = $urandom_range(1, 1 << 24);  depth = $urandom_range(0, 65535); end
				2: begin step = 32'hFFFF_FFFF;               depth = $urandom(); end
				3: begin step = $urandom();                  depth = 32'h0000_0000; end
				4: begin step = $urandom_range(1, 1 << 28);  depth = $urandom(); end
				default: begin step = $urandom();            depth = $urandom(); end
			endcase
			set_lfo(step, depth);
			for (int i = 0; i < 135; i++) begin
				send_frame(rand_sample(), rand_sample(),
					rand_block_end(setting[0] ? 2 : 8));
			end
			await_results();
		end
	endtask

	// The receiver refuses results for a long stretch while frames keep being offered,
	// so the result register fills and the input must stall. Afterwards the sender
	// pauses until every result is back, then carries on without a register change.
	task automatic test_backpressure();
		set_lfo($urandom(), $urandom_range(0, 65535));
		long_hold_cycles = LONG_HOLD;
		for (int i = 0; i < 12; i++) send_frame(rand_sample(), rand_sample(), rand_block_end(4));
		await_results();
		for (int i = 0; i < 20; i++) send_frame(rand_sample(), rand_sample(), rand_block_end(4));
		await_results();
	endtask

	// Final stretch with no idling on either side, at the block's full rate.
	task automatic test_streaming();
		src_gaps    = 1'b0;
		sink_stalls = 1'b0;
		set_lfo($urandom(), $urandom());
		for (int i = 0; i < 180; i++) send_frame(rand_sample(), rand_sample(), rand_block_end(6));
		await_results();
	endtask

	// Receiver side: one decision per stretch, so ready gets one assignment per edge.
	initial begin : result_sink
		results_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (long_hold_cycles != 0) begin
				results_ch.ready <= 1'b0;
				repeat (long_hold_cycles) @(posedge clk);
				long_hold_cycles = 0;
			end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
				results_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				results_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Every result beat is compared with the oldest prediction, field by field.
	always @(posedge clk) begin
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (expected_frames.size() == 0) begin
				$display("%0t: result beat with none expected: got left %0d right %0d phase %0d",
					$time, results_ch.left_out, results_ch.right_out,
					results_ch.published_phase);
				mismatches++;
			end else begin
				oldest_frame = expected_frames.pop_front();
				if (results_ch.left_out !== oldest_frame.left) begin
					$display("%0t: left_out expected %0d, got %0d", $time,
						oldest_frame.left, results_ch.left_out);
					mismatches++;
				end
				if (results_ch.right_out !== oldest_frame.right) begin
					$display("%0t: right_out expected %0d, got %0d", $time,
						oldest_frame.right, results_ch.right_out);
					mismatches++;
				end
				if (results_ch.published_phase !== oldest_frame.phase) begin
					$display("%0t: published_phase expected %0d, got %0d", $time,
						oldest_frame.phase, results_ch.published_phase);
					mismatches++;
				end
			end
		end
	end

	// Guard against a hang: the slowest correct run is far below this.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : run_tests
		arst_n               = 1'b0;
		samples_ch.valid     <= 1'b0;
		samples_ch.left_in   <= '0;
		samples_ch.right_in  <= '0;
		samples_ch.block_end <= 1'b0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.reg_index     <= REG_PHASE_INC;
		cfg_ch.write_data    <= '0;
		mismatches       = 0;
		long_hold_cycles = 0;
		src_gaps         = 1'b1;
		sink_stalls      = 1'b1;
		lfo_phase_now    = '0;
		published_now    = '0;
		phase_step       = PHASE_INC_INIT;
		depth_setting    = '0;
		for (int k = 0; k <= QUARTER_SIZE; k++) sine_quarter_ref[k] = taylor_sine(k);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_bypass_extremes();
		test_quadrant_edges();
		test_register_map();
		test_random_settings();
		test_backpressure();
		test_streaming();

		// Let any stray beat show up before the verdict.
		repeat (SETTLE_TICKS) @(posedge clk);
		if (mismatches == 0 && expected_frames.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
